FILE: hw/rtl/tow_pkg.sv
// Package: shared types, constants and control/status bundles of the trajectory compressor
`timescale 1ns / 1ps

package tow_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int WINDOW_DEPTH_D = 64;
	localparam int DIST_W         = 24;
	localparam int PERIOD_W       = 16;
	localparam int STAMP_W        = 32;
	localparam int FLOOR_W        = 8;
	localparam int MAP_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CFG_DATA_W     = 24;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_DISTANCE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd1;

	localparam logic [DIST_W-1:0]   MAX_DISTANCE_RST  = 24'd256;
	localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 16'd1;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
		logic [STAMP_W-1:0]            stamp;
		logic [FLOOR_W-1:0]            floor_id;
		logic [MAP_W-1:0]              map_mark;
		logic                          end_of_trace;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] out_x;
		logic signed [COORD_WIDTH-1:0] out_y;
		logic [STAMP_W-1:0]            out_stamp;
		logic [FLOOR_W-1:0]            out_floor;
		logic [MAP_W-1:0]              out_map;
		logic                          compressed;
		logic                          last_of_run;
	} point_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_PREV,
		ST_EMIT_IN,
		ST_COMMIT
	} ctl_state_t;

	typedef struct packed {
		logic load_in;
		logic clear_dev;
		logic scan_start;
		logic scan_step;
		logic emit_prev;
		logic emit_in;
		logic emit_comp;
		logic emit_last;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic seen_first;
		logic near;
		logic same_run;
		logic count_zero;
		logic full;
		logic scan_end;
		logic pipe_busy;
		logic dev;
		logic out_free;
		logic eot;
	} dp_status_t;

endpackage

FILE: hw/rtl/tow_ctrl.sv
// Controller: sequences one point through prepare, window scan, emits and commit
`timescale 1ns / 1ps

module tow_ctrl import tow_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pt_valid,
	output logic       pt_ready,
	input  dp_status_t status,
	output ctl_cmd_t   cmd
);

	ctl_state_t state_q, state_d;
	logic       prep_cnt_q;
	logic       bad;

	// State register and prepare counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			prep_cnt_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			prep_cnt_q <= (state_q == ST_PREP) ? ~prep_cnt_q : 1'b0;
		end
	end

	assign bad = status.dev || status.full;

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		pt_ready       = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pt_ready = 1'b1;
				if (pt_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.clear_dev  = 1'b1;
				cmd.scan_start = 1'b1;
				if (prep_cnt_q) begin
					if (!status.seen_first)
						state_d = ST_EMIT_IN;
					else if (status.same_run)
						state_d = ST_SCAN;
					else if (!status.count_zero)
						state_d = ST_EMIT_PREV;
					else
						state_d = ST_EMIT_IN;
				end
			end
			ST_SCAN: begin
				if (status.scan_end)
					state_d = ST_DRAIN;
				else
					cmd.scan_step = 1'b1;
			end
			ST_DRAIN: begin
				if (!status.pipe_busy) begin
					if (bad)
						state_d = ST_EMIT_PREV;
					else if (status.eot)
						state_d = ST_EMIT_IN;
					else
						state_d = ST_COMMIT;
				end
			end
			ST_EMIT_PREV: begin
				if (status.out_free) begin
					cmd.emit_prev = 1'b1;
					cmd.emit_comp = 1'b1;
					cmd.emit_last = status.same_run && !status.eot;
					if (status.same_run && !status.eot)
						state_d = ST_COMMIT;
					else
						state_d = ST_EMIT_IN;
				end
			end
			ST_EMIT_IN: begin
				if (status.out_free) begin
					cmd.emit_in   = 1'b1;
					cmd.emit_comp = !status.seen_first || status.near;
					cmd.emit_last = 1'b1;
					state_d       = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/tow_dp.sv
// Datapath: point registers, window memory, deviation pipeline and output register
`timescale 1ns / 1ps

module tow_dp import tow_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  point_in_t             pt,
	input  logic                  kept_ready,
	output logic                  kept_valid,
	output point_out_t            kept,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctl_cmd_t              cmd,
	output dp_status_t            status
);

	localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int NW  = $clog2(WINDOW_DEPTH + 1);
	localparam int CW  = $clog2(WINDOW_DEPTH + 2);
	localparam int DW  = COORD_WIDTH + 1;
	localparam int PW  = DW + CW + 1;
	localparam int EW  = PW + 1;
	localparam int L   = (EW + 1) / 2;
	localparam int H   = EW - L;
	localparam int SQW = 2 * EW;
	localparam int SW  = SQW + 1;
	localparam int TW  = DIST_W + CW;
	localparam int TL  = (TW + 1) / 2;
	localparam int TH  = TW - TL;
	localparam int TSW = 2 * TW;

	// Configuration
	logic [DIST_W-1:0]   max_distance_q;
	logic [PERIOD_W-1:0] sample_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_distance_q  <= MAX_DISTANCE_RST;
			sample_period_q <= SAMPLE_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_DISTANCE:  max_distance_q  <= cfg_data;
				REG_SAMPLE_PERIOD: sample_period_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// Trajectory state
	point_in_t                     in_q;
	logic signed [COORD_WIDTH-1:0] anc_x_q, anc_y_q;
	logic [FLOOR_W-1:0]            anc_floor_q;
	logic [MAP_W-1:0]              anc_map_q;
	logic signed [COORD_WIDTH-1:0] prv_x_q, prv_y_q;
	logic [STAMP_W-1:0]            prv_stamp_q;
	logic [FLOOR_W-1:0]            prv_floor_q;
	logic [MAP_W-1:0]              prv_map_q;
	logic                          seen_q;
	logic                          near_q, same_q;
	logic [NW-1:0]                 count_q;
	logic [NW-1:0]                 idx_q;
	logic                          dev_q;
	logic                          full;
	logic                          bad;
	logic [CW-1:0]                 r;

	logic signed [COORD_WIDTH-1:0] mem_x [WINDOW_DEPTH];
	logic signed [COORD_WIDTH-1:0] mem_y [WINDOW_DEPTH];
	logic [AW-1:0]                 wr_addr;

	assign full    = (count_q == NW'(WINDOW_DEPTH));
	assign bad     = dev_q || full;
	assign r       = CW'(count_q) + CW'(1);
	assign wr_addr = bad ? '0 : count_q[AW-1:0];

	// Capture point word
	always_ff @(posedge clk) begin
		if (cmd.load_in)
			in_q <= pt;
	end

	// Control state: run flags, window fill, scan index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q  <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.scan_start)
				idx_q <= '0;
			else if (cmd.scan_step)
				idx_q <= idx_q + NW'(1);
			if (cmd.commit) begin
				if (!seen_q || !same_q)
					count_q <= '0;
				else if (bad)
					count_q <= NW'(1);
				else
					count_q <= count_q + NW'(1);
				seen_q <= 1'b1;
				if (in_q.end_of_trace) begin
					seen_q  <= 1'b0;
					count_q <= '0;
				end
			end
		end
	end

	// Update anchor and previous point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_x_q     <= '0;
			anc_y_q     <= '0;
			anc_floor_q <= '0;
			anc_map_q   <= '0;
			prv_x_q     <= '0;
			prv_y_q     <= '0;
			prv_stamp_q <= '0;
			prv_floor_q <= '0;
			prv_map_q   <= '0;
		end else if (cmd.commit) begin
			if (!seen_q || !same_q) begin
				anc_x_q     <= in_q.pos_x;
				anc_y_q     <= in_q.pos_y;
				anc_floor_q <= in_q.floor_id;
				anc_map_q   <= in_q.map_mark;
			end else if (bad) begin
				anc_x_q     <= prv_x_q;
				anc_y_q     <= prv_y_q;
				anc_floor_q <= prv_floor_q;
				anc_map_q   <= prv_map_q;
			end
			prv_x_q     <= in_q.pos_x;
			prv_y_q     <= in_q.pos_y;
			prv_stamp_q <= in_q.stamp;
			prv_floor_q <= in_q.floor_id;
			prv_map_q   <= in_q.map_mark;
		end
	end

	// Window memory: write on commit, read during scan
	logic signed [COORD_WIDTH-1:0] wx_s1, wy_s1;
	logic [CW-1:0]                 n_s1;
	logic                          v_s1;

	always_ff @(posedge clk) begin
		if (cmd.commit && seen_q && same_q) begin
			mem_x[wr_addr] <= in_q.pos_x;
			mem_y[wr_addr] <= in_q.pos_y;
		end
		if (cmd.scan_step) begin
			wx_s1 <= mem_x[idx_q[AW-1:0]];
			wy_s1 <= mem_y[idx_q[AW-1:0]];
		end
		n_s1 <= CW'(idx_q) + CW'(1);
	end

	// Per-point prepare: gap test, run test, line delta, squared limit
	logic signed [STAMP_W:0] diff;
	logic signed [STAMP_W:0] thr;
	logic signed [DW-1:0]    dx_q, dy_q;
	logic [TW-1:0]           tm_q;
	logic [2*TH-1:0]         thh_q;
	logic [TH+TL-1:0]        thl_q;
	logic [2*TL-1:0]         tll_q;
	logic [TSW-1:0]          tsq_q;

	assign diff = $signed({1'b0, in_q.stamp}) - $signed({1'b0, prv_stamp_q});
	assign thr  = $signed({{(STAMP_W - PERIOD_W){1'b0}}, sample_period_q, 1'b0});

	always_ff @(posedge clk) begin
		near_q <= diff < thr;
		same_q <= (diff < thr) && (in_q.floor_id == anc_floor_q)
			&& (in_q.map_mark == anc_map_q);
		dx_q   <= DW'(in_q.pos_x) - DW'(anc_x_q);
		dy_q   <= DW'(in_q.pos_y) - DW'(anc_y_q);
		tm_q   <= TW'(max_distance_q) * TW'(r);
		thh_q  <= tm_q[TW-1:TL] * tm_q[TW-1:TL];
		thl_q  <= (TH+TL)'(tm_q[TW-1:TL]) * (TH+TL)'(tm_q[TL-1:0]);
		tll_q  <= tm_q[TL-1:0] * tm_q[TL-1:0];
		tsq_q  <= {thh_q, {(2*TL){1'b0}}} + (TSW'(thl_q) << (TL + 1)) + TSW'(tll_q);
	end

	// Deviation pipeline
	logic                 v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [DW-1:0] ax_s2, ay_s2;
	logic [CW-1:0]        n_s2;
	logic signed [PW-1:0] px_s3, py_s3, qx_s3, qy_s3;
	logic signed [EW-1:0] ex_s4, ey_s4;
	logic [EW-1:0]        mx_s5, my_s5;
	logic [2*H-1:0]       hhx_s6, hhy_s6;
	logic [H+L-1:0]       hlx_s6, hly_s6;
	logic [2*L-1:0]       llx_s6, lly_s6;
	logic [SQW-1:0]       sqx_s7, sqy_s7;
	logic [SW-1:0]        sum_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		ax_s2  <= DW'(wx_s1) - DW'(anc_x_q);
		ay_s2  <= DW'(wy_s1) - DW'(anc_y_q);
		n_s2   <= n_s1;
		px_s3  <= PW'(ax_s2) * PW'($signed({1'b0, r}));
		py_s3  <= PW'(ay_s2) * PW'($signed({1'b0, r}));
		qx_s3  <= PW'(dx_q) * PW'($signed({1'b0, n_s2}));
		qy_s3  <= PW'(dy_q) * PW'($signed({1'b0, n_s2}));
		ex_s4  <= {px_s3[PW-1], px_s3} - {qx_s3[PW-1], qx_s3};
		ey_s4  <= {py_s3[PW-1], py_s3} - {qy_s3[PW-1], qy_s3};
		mx_s5  <= ex_s4[EW-1] ? EW'(-ex_s4) : EW'(ex_s4);
		my_s5  <= ey_s4[EW-1] ? EW'(-ey_s4) : EW'(ey_s4);
		hhx_s6 <= mx_s5[EW-1:L] * mx_s5[EW-1:L];
		hlx_s6 <= (H+L)'(mx_s5[EW-1:L]) * (H+L)'(mx_s5[L-1:0]);
		llx_s6 <= mx_s5[L-1:0] * mx_s5[L-1:0];
		hhy_s6 <= my_s5[EW-1:L] * my_s5[EW-1:L];
		hly_s6 <= (H+L)'(my_s5[EW-1:L]) * (H+L)'(my_s5[L-1:0]);
		lly_s6 <= my_s5[L-1:0] * my_s5[L-1:0];
		sqx_s7 <= {hhx_s6, {(2*L){1'b0}}} + (SQW'(hlx_s6) << (L + 1)) + SQW'(llx_s6);
		sqy_s7 <= {hhy_s6, {(2*L){1'b0}}} + (SQW'(hly_s6) << (L + 1)) + SQW'(lly_s6);
	end

	assign sum_s7 = SW'(sqx_s7) + SW'(sqy_s7);

	// Accumulate deviation over the scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dev_q <= 1'b0;
		else if (cmd.clear_dev)
			dev_q <= 1'b0;
		else if (v_s7 && (sum_s7 > SW'(tsq_q)))
			dev_q <= 1'b1;
	end

	// Output register
	logic       out_valid_q;
	point_out_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_prev || cmd.emit_in)
			out_valid_q <= 1'b1;
		else if (kept_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_prev) begin
			out_q.out_x     <= prv_x_q;
			out_q.out_y     <= prv_y_q;
			out_q.out_stamp <= prv_stamp_q;
			out_q.out_floor <= prv_floor_q;
			out_q.out_map   <= prv_map_q;
		end else if (cmd.emit_in) begin
			out_q.out_x     <= in_q.pos_x;
			out_q.out_y     <= in_q.pos_y;
			out_q.out_stamp <= in_q.stamp;
			out_q.out_floor <= in_q.floor_id;
			out_q.out_map   <= in_q.map_mark;
		end
		if (cmd.emit_prev || cmd.emit_in) begin
			out_q.compressed  <= cmd.emit_comp;
			out_q.last_of_run <= cmd.emit_last;
		end
	end

	assign kept_valid = out_valid_q;
	assign kept       = out_q;

	// Status toward the controller
	always_comb begin
		status.seen_first = seen_q;
		status.near       = near_q;
		status.same_run   = same_q;
		status.count_zero = (count_q == '0);
		status.full       = full;
		status.scan_end   = (idx_q == count_q);
		status.pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6 || v_s7;
		status.dev        = dev_q;
		status.out_free   = !out_valid_q || kept_ready;
		status.eot        = in_q.end_of_trace;
	end

endmodule

FILE: hw/rtl/trajectory_opening_window_compress.sv
// Sequence: a point is taken while idle, then prepared; a point that continues the run
// has the window scanned and the deviation pipeline drained; then each result is emitted
// and the point is committed.
// A new point is taken only after the previous one is committed; output stalls hold the
// emit states and so delay the commit.
// The output register lets a result wait while the next point is taken.
// Reset (arst_n low): registers to defaults, window empty; window memory is not cleared.
`timescale 1ns / 1ps

module trajectory_opening_window_compress import tow_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pt_valid,
	output logic                  pt_ready,
	input  point_in_t             pt,
	output logic                  kept_valid,
	input  logic                  kept_ready,
	output point_out_t            kept,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Sequencer
	tow_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.pt_valid (pt_valid),
		.pt_ready (pt_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Window store and arithmetic
	tow_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.pt         (pt),
		.kept_ready (kept_ready),
		.kept_valid (kept_valid),
		.kept       (kept),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.status     (status)
	);

endmodule
